// File: hw/rtl/grr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types, register indexes and the 5x7 font table of the glyph
// rectangle rasterizer.
// ----------------------------------------------------------------------------
package grr_pkg;

   localparam int FontCols = 5;
   localparam int FontRows = 7;

   localparam logic [7:0] CodeDigit0 = 8'h30;
   localparam logic [7:0] CodeDigit9 = 8'h39;
   localparam logic [7:0] CodeLetterA = 8'h41;
   localparam logic [7:0] CodeLetterZ = 8'h5A;

   localparam logic [2:0] LastCol = 3'd4;
   localparam logic [2:0] LastRow = 3'd6;

   // configuration register indexes
   localparam logic [1:0] CSR_GLYPH_SCALE   = 2'd0;
   localparam logic [1:0] CSR_TEXT_COLOR    = 2'd1;
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd3;

   localparam logic [7:0]  ResetScale  = 8'd1;
   localparam logic [15:0] ResetColor  = 16'hFFFF;
   localparam logic [11:0] ResetWidth  = 12'd320;
   localparam logic [11:0] ResetHeight = 12'd240;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic        hit;
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  w;
      logic [7:0]  h;
   } dot_type;

   // one glyph per entry, column c in bits [7c+6:7c], bit r is row r
   localparam logic [34:0] FONT_ROM [36] = '{
      {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E},
      {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00},
      {7'h46, 7'h49, 7'h51, 7'h61, 7'h42},
      {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21},
      {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18},
      {7'h39, 7'h45, 7'h45, 7'h45, 7'h27},
      {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C},
      {7'h03, 7'h05, 7'h09, 7'h71, 7'h01},
      {7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
      {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06},
      {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E},
      {7'h36, 7'h49, 7'h49, 7'h49, 7'h7F},
      {7'h22, 7'h41, 7'h41, 7'h41, 7'h3E},
      {7'h1C, 7'h22, 7'h41, 7'h41, 7'h7F},
      {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F},
      {7'h01, 7'h09, 7'h09, 7'h09, 7'h7F},
      {7'h7A, 7'h49, 7'h49, 7'h41, 7'h3E},
      {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
      {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00},
      {7'h01, 7'h3F, 7'h41, 7'h40, 7'h20},
      {7'h41, 7'h22, 7'h14, 7'h08, 7'h7F},
      {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F},
      {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F},
      {7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F},
      {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E},
      {7'h06, 7'h09, 7'h09, 7'h09, 7'h7F},
      {7'h5E, 7'h21, 7'h51, 7'h41, 7'h3E},
      {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F},
      {7'h31, 7'h49, 7'h49, 7'h49, 7'h46},
      {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
      {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F},
      {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
      {7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F},
      {7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
      {7'h07, 7'h08, 7'h70, 7'h08, 7'h07},
      {7'h43, 7'h45, 7'h49, 7'h51, 7'h61}
   };

   // dot column of a character, blank for codes without a glyph
   function automatic logic [6:0] font_col(input logic [7:0] code, input logic [2:0] col);
      logic [7:0]  gidx;
      logic        has_glyph;
      logic [34:0] glyph;
      gidx      = 8'd0;
      has_glyph = 1'b0;
      glyph     = '0;
      if (code >= CodeDigit0 && code <= CodeDigit9) begin
         gidx      = code - CodeDigit0;
         has_glyph = 1'b1;
      end else if (code >= CodeLetterA && code <= CodeLetterZ) begin
         gidx      = code - CodeLetterA + 8'd10;
         has_glyph = 1'b1;
      end
      if (has_glyph) begin
         glyph = FONT_ROM[gidx[5:0]];
      end
      case (col)
         3'd0:    font_col = glyph[6:0];
         3'd1:    font_col = glyph[13:7];
         3'd2:    font_col = glyph[20:14];
         3'd3:    font_col = glyph[27:21];
         3'd4:    font_col = glyph[34:28];
         default: font_col = 7'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/grr_dot_clip.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grr_dot_clip
// Screen test and clipping of one font dot square at a wrapped position.
// ----------------------------------------------------------------------------
module grr_dot_clip
   import grr_pkg::*;
(
   input  wire logic        dot_set,
   input  wire logic [15:0] pos_x,
   input  wire logic [15:0] pos_y,
   input  wire logic [7:0]  scale,
   input  wire logic [11:0] screen_w,
   input  wire logic [11:0] screen_h,
   output dot_type          dot
);

   logic        on_x;
   logic        on_y;
   logic [12:0] end_x;
   logic [12:0] end_y;
   logic [11:0] room_x;
   logic [11:0] room_y;

   always_comb begin
      on_x   = pos_x < {4'd0, screen_w};
      on_y   = pos_y < {4'd0, screen_h};
      end_x  = {1'b0, pos_x[11:0]} + {5'd0, scale};
      end_y  = {1'b0, pos_y[11:0]} + {5'd0, scale};
      room_x = screen_w - pos_x[11:0];
      room_y = screen_h - pos_y[11:0];

      dot.hit = dot_set && (scale != 8'd0) && on_x && on_y;
      dot.x   = pos_x[11:0];
      dot.y   = pos_y[11:0];
      // clipped room is below scale whenever the square runs past the edge
      dot.w   = (end_x > {1'b0, screen_w}) ? room_x[7:0] : scale;
      dot.h   = (end_y > {1'b0, screen_h}) ? room_y[7:0] : scale;
   end

endmodule
`default_nettype wire

// File: hw/rtl/glyph_rect_rasterizer_top.sv
`default_nettype none
// Flow: a request is taken only while idle, then the scan state visits the 35
// dots column by column, then the flush state sends the final rectangle, if any.
// A new character is not taken until the previous one is through flush; the
// single clip unit checks one dot at a time, and rsp_stall can hold the scan.
// Reset: pen position cleared, registers back to scale 1, white, 320x240,
// sequencer idle and no result beat pending.
// ----------------------------------------------------------------------------
// glyph_rect_rasterizer_top
// 5x7 font character generator that turns each set dot that lands on the
// screen into a clipped filled rectangle.
// ----------------------------------------------------------------------------
module glyph_rect_rasterizer_top
   import grr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [15:0] req_origin_x,
   input  wire logic [15:0] req_origin_y,
   input  wire logic        req_new_string,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_rect_x,
   output logic [11:0]      rsp_rect_y,
   output logic [7:0]       rsp_rect_width,
   output logic [7:0]       rsp_rect_height,
   output logic [15:0]      rsp_rect_color,
   output logic             rsp_last_rect,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   state_type   state_ff, state_in;

   logic [7:0]  scale_ff;
   logic [15:0] color_ff;
   logic [11:0] screen_w_ff;
   logic [11:0] screen_h_ff;

   logic [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic [15:0] cur_x_ff, cur_x_in;
   logic [15:0] cur_y_ff, cur_y_in;
   logic [2:0]  col_ff, col_in;
   logic [2:0]  row_ff, row_in;
   logic [7:0]  code_ff, code_in;

   dot_type     pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;

   logic        out_valid_ff, out_valid_in;
   dot_type     out_dot_ff, out_dot_in;
   logic        out_last_ff, out_last_in;

   logic [6:0]  col_bits;
   dot_type     dot;
   logic        out_free;
   logic        accept;
   logic [15:0] step;
   logic [15:0] advance;

   assign col_bits = font_col(code_ff, col_ff);
   assign step     = {8'd0, scale_ff};
   assign advance  = {6'd0, scale_ff, 2'd0} + {7'd0, scale_ff, 1'd0};

   grr_dot_clip u_dot_clip (
      .dot_set  (col_bits[row_ff]),
      .pos_x    (cur_x_ff),
      .pos_y    (cur_y_ff),
      .scale    (scale_ff),
      .screen_w (screen_w_ff),
      .screen_h (screen_h_ff),
      .dot      (dot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      code_in       = code_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_dot_in    = out_dot_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               code_in  = req_char_code;
               col_in   = 3'd0;
               row_in   = 3'd0;
               state_in = ST_SCAN;
               if (req_new_string) begin
                  pen_x_in = req_origin_x;
                  pen_y_in = req_origin_y;
                  cur_x_in = req_origin_x;
                  cur_y_in = req_origin_y;
               end else begin
                  cur_x_in = pen_x_ff;
                  cur_y_in = pen_y_ff;
               end
            end
         end
         ST_SCAN: begin
            // a hit pushes the held rectangle out, so it waits for a free slot
            if (!dot.hit || !pend_valid_ff || out_free) begin
               if (dot.hit) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_dot_in   = pend_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_in       = dot;
                  pend_valid_in = 1'b1;
               end
               if (row_ff == LastRow) begin
                  row_in   = 3'd0;
                  cur_y_in = pen_y_ff;
                  if (col_ff == LastCol) begin
                     state_in = ST_FLUSH;
                  end else begin
                     col_in   = col_ff + 3'd1;
                     cur_x_in = cur_x_ff + step;
                  end
               end else begin
                  row_in   = row_ff + 3'd1;
                  cur_y_in = cur_y_ff + step;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_dot_in    = pend_ff;
                  out_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
               end
               pen_x_in = pen_x_ff + advance;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pen_x_ff      <= 16'd0;
         pen_y_ff      <= 16'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         col_ff        <= 3'd0;
         row_ff        <= 3'd0;
      end else begin
         state_ff      <= state_in;
         pen_x_ff      <= pen_x_in;
         pen_y_ff      <= pen_y_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      code_ff     <= code_in;
      pend_ff     <= pend_in;
      out_dot_ff  <= out_dot_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= ResetScale;
         color_ff    <= ResetColor;
         screen_w_ff <= ResetWidth;
         screen_h_ff <= ResetHeight;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GLYPH_SCALE:   scale_ff    <= csr_data[7:0];
            CSR_TEXT_COLOR:    color_ff    <= csr_data;
            CSR_SCREEN_WIDTH:  screen_w_ff <= csr_data[11:0];
            CSR_SCREEN_HEIGHT: screen_h_ff <= csr_data[11:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_rect_x      = out_dot_ff.x;
   assign rsp_rect_y      = out_dot_ff.y;
   assign rsp_rect_width  = out_dot_ff.w;
   assign rsp_rect_height = out_dot_ff.h;
   assign rsp_rect_color  = color_ff;
   assign rsp_last_rect   = out_last_ff;

`ifndef SYNTHESIS
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted beat did not start a scan");

   a_idle_no_held_rect: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held rectangle left behind at idle");

   a_scan_counters: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (row_ff <= LastRow && col_ff <= LastCol))
      else $error("dot counters out of range");

   a_nonzero_size: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_dot_ff.w != 8'd0 && out_dot_ff.h != 8'd0))
      else $error("empty rectangle on the result channel");
`endif

endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the glyph rectangle rasterizer. Characters go in with random
// gaps. The rectangle channel is stalled at random. Every rectangle beat is
// compared against a font walker kept in the bench, which follows the pen
// position and the register settings.
// ----------------------------------------------------------------------------
module tb_top
   import grr_pkg::*;
();

   localparam int SETTLE_CYCLES  = 45;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PEN_STEP       = 6;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  w;
      logic [7:0]  h;
      logic [15:0] color;
      logic        last;
   } rect_type;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code  = '0;
   logic [15:0] req_origin_x   = '0;
   logic [15:0] req_origin_y   = '0;
   logic        req_new_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [11:0] rsp_rect_x;
   logic [11:0] rsp_rect_y;
   logic [7:0]  rsp_rect_width;
   logic [7:0]  rsp_rect_height;
   logic [15:0] rsp_rect_color;
   logic        rsp_last_rect;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index      = CSR_GLYPH_SCALE;
   logic [15:0] csr_data       = '0;

   // predictor state
   logic [7:0]  cfg_scale  = ResetScale;
   logic [15:0] cfg_color  = ResetColor;
   logic [11:0] cfg_width  = ResetWidth;
   logic [11:0] cfg_height = ResetHeight;
   logic [15:0] pen_x      = '0;
   logic [15:0] pen_y      = '0;

   rect_type expected_rects[$];
   int    error_count = 0;
   int    quiet_cycles = 0;
   int    burst_left = 0;

   glyph_rect_rasterizer_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_new_string  (req_new_string),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rect_x      (rsp_rect_x),
      .rsp_rect_y      (rsp_rect_y),
      .rsp_rect_width  (rsp_rect_width),
      .rsp_rect_height (rsp_rect_height),
      .rsp_rect_color  (rsp_rect_color),
      .rsp_last_rect   (rsp_last_rect),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // five column bytes, column 0 in the top byte, bit r of a column is row r
   function automatic logic [39:0] font_glyph(input logic [7:0] code);
      int idx;
      idx = -1;
      if (code >= CodeDigit0 && code <= CodeDigit9) idx = int'(code - CodeDigit0);
      else if (code >= CodeLetterA && code <= CodeLetterZ) idx = int'(code - CodeLetterA) + 10;
      case (idx)
         0:  font_glyph = 40'h3E_51_49_45_3E;
         1:  font_glyph = 40'h00_42_7F_40_00;
         2:  font_glyph = 40'h42_61_51_49_46;
         3:  font_glyph = 40'h21_41_45_4B_31;
         4:  font_glyph = 40'h18_14_12_7F_10;
         5:  font_glyph = 40'h27_45_45_45_39;
         6:  font_glyph = 40'h3C_4A_49_49_30;
         7:  font_glyph = 40'h01_71_09_05_03;
         8:  font_glyph = 40'h36_49_49_49_36;
         9:  font_glyph = 40'h06_49_49_29_1E;
         10: font_glyph = 40'h7E_11_11_11_7E;
         11: font_glyph = 40'h7F_49_49_49_36;
         12: font_glyph = 40'h3E_41_41_41_22;
         13: font_glyph = 40'h7F_41_41_22_1C;
         14: font_glyph = 40'h7F_49_49_49_41;
         15: font_glyph = 40'h7F_09_09_09_01;
         16: font_glyph = 40'h3E_41_49_49_7A;
         17: font_glyph = 40'h7F_08_08_08_7F;
         18: font_glyph = 40'h00_41_7F_41_00;
         19: font_glyph = 40'h20_40_41_3F_01;
         20: font_glyph = 40'h7F_08_14_22_41;
         21: font_glyph = 40'h7F_40_40_40_40;
         22: font_glyph = 40'h7F_02_0C_02_7F;
         23: font_glyph = 40'h7F_04_08_10_7F;
         24: font_glyph = 40'h3E_41_41_41_3E;
         25: font_glyph = 40'h7F_09_09_09_06;
         26: font_glyph = 40'h3E_41_51_21_5E;
         27: font_glyph = 40'h7F_09_19_29_46;
         28: font_glyph = 40'h46_49_49_49_31;
         29: font_glyph = 40'h01_01_7F_01_01;
         30: font_glyph = 40'h3F_40_40_40_3F;
         31: font_glyph = 40'h1F_20_40_20_1F;
         32: font_glyph = 40'h7F_20_18_20_7F;
         33: font_glyph = 40'h63_14_08_14_63;
         34: font_glyph = 40'h07_08_70_08_07;
         35: font_glyph = 40'h61_51_49_45_43;
         default: font_glyph = '0;
      endcase
   endfunction

   // walks the dots of one character and queues the clipped rectangles
   task automatic rasterize_char(input logic [7:0] code, input logic [15:0] ox,
                                 input logic [15:0] oy, input logic ns);
      logic [39:0] glyph;
      logic [7:0]  dots;
      logic [15:0] rx, ry;
      int          xi, yi, w, h;
      rect_type    held;
      bit          have_held;
      have_held = 0;
      held = '0;
      if (ns) begin
         pen_x = ox;
         pen_y = oy;
      end
      glyph = font_glyph(code);
      for (int c = 0; c < FontCols; c++) begin
         dots = glyph[39 - 8*c -: 8];
         for (int r = 0; r < FontRows; r++) begin
            if (dots[r] && cfg_scale != 0) begin
               rx = 16'(pen_x + c * cfg_scale);
               ry = 16'(pen_y + r * cfg_scale);
               xi = int'(rx);
               yi = int'(ry);
               if (xi < cfg_width && yi < cfg_height) begin
                  w = int'(cfg_scale);
                  h = int'(cfg_scale);
                  if (xi + w > cfg_width) w = cfg_width - xi;
                  if (yi + h > cfg_height) h = cfg_height - yi;
                  // hold one back so the final one can carry the last flag
                  if (have_held) expected_rects.push_back(held);
                  held = '{x: rx[11:0], y: ry[11:0], w: w[7:0], h: h[7:0],
                           color: cfg_color, last: 1'b0};
                  have_held = 1;
               end
            end
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         expected_rects.push_back(held);
      end
      pen_x = 16'(pen_x + PEN_STEP * cfg_scale);
   endtask

   // called at a clock edge; leaves valid high for a back-to-back beat
   task automatic send_char(input logic [7:0] code, input logic [15:0] ox,
                            input logic [15:0] oy, input logic ns);
      int gap, sel;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 3) burst_left = $urandom_range(15, 40);
         else if (sel < 50) gap = 0;
         else if (sel < 85) gap = $urandom_range(1, 3);
         else if (sel < 95) gap = $urandom_range(4, 10);
         else gap = $urandom_range(20, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_code  <= code;
      req_origin_x   <= ox;
      req_origin_y   <= oy;
      req_new_string <= ns;
      do @(posedge clock); while (req_stall);
      rasterize_char(code, ox, oy, ns);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (expected_rects.size() != 0) @(posedge clock);
      // a blank character may still be scanning
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GLYPH_SCALE:   cfg_scale  = data[7:0];
         CSR_TEXT_COLOR:    cfg_color  = data;
         CSR_SCREEN_WIDTH:  cfg_width  = data[11:0];
         CSR_SCREEN_HEIGHT: cfg_height = data[11:0];
         default: ;
      endcase
   endtask

   task automatic test_code_ranges();
      send_char(CodeDigit0, 16'd0, 16'd0, 1'b1);
      send_char(CodeDigit9, 16'hFFFF, 16'hFFFF, 1'b0);
      send_char(CodeLetterA, 16'd0, 16'd0, 1'b0);
      send_char(CodeLetterZ, 16'd0, 16'd0, 1'b0);
      send_char(CodeDigit0 - 8'd1, 16'd0, 16'd0, 1'b0);
      send_char(CodeDigit9 + 8'd1, 16'd0, 16'd0, 1'b0);
      send_char(CodeLetterA - 8'd1, 16'd0, 16'd0, 1'b0);
      send_char(CodeLetterZ + 8'd1, 16'd0, 16'd0, 1'b0);
      send_char(8'h00, 16'd0, 16'd0, 1'b0);
      send_char(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
      // partly below the bottom edge
      send_char("H", 16'd315, 16'd236, 1'b1);
   endtask

   task automatic test_large_scale_clip();
      hold_until_drained();
      write_reg(CSR_GLYPH_SCALE, 16'hFF);
      write_reg(CSR_TEXT_COLOR, 16'h0000);
      write_reg(CSR_SCREEN_WIDTH, 16'd4095);
      write_reg(CSR_SCREEN_HEIGHT, 16'd4095);
      send_char("M", 16'd0, 16'd0, 1'b1);
      send_char("W", 16'd3900, 16'd3950, 1'b1);
      // pen wraps from the top of the 16-bit range
      send_char("8", 16'hFFFF, 16'hFFFF, 1'b1);
      hold_until_drained();
      write_reg(CSR_SCREEN_WIDTH, 16'd1);
      write_reg(CSR_SCREEN_HEIGHT, 16'd1);
      send_char("X", 16'd0, 16'd0, 1'b1);
   endtask

   task automatic test_zero_scale();
      hold_until_drained();
      write_reg(CSR_GLYPH_SCALE, 16'd0);
      write_reg(CSR_SCREEN_WIDTH, 16'd320);
      write_reg(CSR_SCREEN_HEIGHT, 16'd240);
      send_char("B", 16'd10, 16'd10, 1'b1);
      send_char("8", 16'd0, 16'd0, 1'b0);
      hold_until_drained();
      // pen must still be at the string origin
      write_reg(CSR_GLYPH_SCALE, 16'd3);
      send_char("E", 16'd0, 16'd0, 1'b0);
   endtask

   task automatic test_zero_screen();
      hold_until_drained();
      write_reg(CSR_SCREEN_WIDTH, 16'd0);
      send_char("K", 16'd0, 16'd0, 1'b1);
      hold_until_drained();
      write_reg(CSR_SCREEN_WIDTH, 16'd320);
      write_reg(CSR_SCREEN_HEIGHT, 16'd0);
      send_char("K", 16'd0, 16'd0, 1'b1);
      hold_until_drained();
      write_reg(CSR_SCREEN_HEIGHT, 16'd240);
      send_char("K", 16'd0, 16'd0, 1'b1);
   endtask

   function automatic logic [15:0] random_extent();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) random_extent = 16'd4095;
      else if (sel == 1) random_extent = 16'($urandom_range(1, 20));
      else random_extent = 16'($urandom_range(100, 800));
      // upper bits are outside the register
      random_extent[15:12] = 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [7:0] random_code();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) random_code = 8'(CodeLetterA + $urandom_range(0, 25));
      else if (sel < 8) random_code = 8'(CodeDigit0 + $urandom_range(0, 9));
      else random_code = 8'($urandom_range(0, 255));
   endfunction

   task automatic run_text(input int n_items);
      int          sent, len, sel;
      logic [15:0] ox, oy;
      logic        ns;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 12);
         for (int k = 0; k < len && sent < n_items; k++) begin
            ns = (k == 0) || ($urandom_range(0, 19) == 0);
            sel = $urandom_range(0, 9);
            if (!ns || sel == 0) begin
               ox = 16'($urandom_range(0, 65535));
               oy = 16'($urandom_range(0, 65535));
            end else if (sel == 1) begin
               ox = 16'(16'hFFFF - $urandom_range(0, 300));
               oy = 16'(16'hFFFF - $urandom_range(0, 300));
            end else begin
               ox = 16'($urandom_range(0, cfg_width + 8));
               oy = 16'($urandom_range(0, cfg_height + 8));
            end
            send_char(random_code(), ox, oy, ns);
            sent++;
         end
      end
   endtask

   task automatic test_random_text();
      logic [15:0] scale;
      for (int p = 0; p < 7; p++) begin
         hold_until_drained();
         scale = 16'($urandom_range(0, 255) << 8);
         if ($urandom_range(0, 9) == 0) scale[7:0] = 8'($urandom_range(100, 255));
         else scale[7:0] = 8'($urandom_range(1, 8));
         write_reg(CSR_GLYPH_SCALE, scale);
         write_reg(CSR_TEXT_COLOR, 16'($urandom_range(0, 65535)));
         write_reg(CSR_SCREEN_WIDTH, random_extent());
         write_reg(CSR_SCREEN_HEIGHT, random_extent());
         run_text(47);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_code_ranges();
      test_large_scale_clip();
      test_zero_scale();
      test_zero_screen();
      test_random_text();
      hold_until_drained();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // rect channel backpressure: short and long stalls, with quiet stretches
   initial begin : rsp_stall_gen
      int   sel, hold;
      logic level;
      forever begin
         sel = $urandom_range(0, 15);
         if (sel == 0) begin
            hold = $urandom_range(100, 300);
            level = 1'b0;
         end else if (sel < 10) begin
            hold = $urandom_range(1, 6);
            level = 1'b0;
         end else if (sel < 15) begin
            hold = $urandom_range(1, 3);
            level = 1'b1;
         end else begin
            hold = $urandom_range(20, 60);
            level = 1'b1;
         end
         repeat (hold) begin
            @(posedge clock);
            rsp_stall <= level;
         end
      end
   end

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: rect %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rects.size() == 0) begin
            $display("%0t: unexpected rect beat, expected none, actual x=%0d y=%0d",
                     $time, rsp_rect_x, rsp_rect_y);
            error_count++;
         end else begin
            want = expected_rects.pop_front();
            check_field("x", 16'(want.x), 16'(rsp_rect_x));
            check_field("y", 16'(want.y), 16'(rsp_rect_y));
            check_field("width", 16'(want.w), 16'(rsp_rect_width));
            check_field("height", 16'(want.h), 16'(rsp_rect_height));
            check_field("color", want.color, rsp_rect_color);
            check_field("last", 16'(want.last), 16'(rsp_last_rect));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
`default_nettype wire

// File: sim.f
hw/rtl/grr_pkg.sv
hw/rtl/grr_dot_clip.sv
hw/rtl/glyph_rect_rasterizer_top.sv
test/tb_top.sv
